// ----- design/fasc_pkg.sv -----
// ----------------------------------------------------------------------------
// fasc_pkg
// Shared types, constants and helpers for the float add/sub/convert unit.
// ----------------------------------------------------------------------------
package fasc_pkg;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_NEG = 3'd2,
    FUNC_I2F = 3'd3,
    FUNC_F2I = 3'd4
  } func_e;

  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] EXP_FIELD  = 32'h7F80_0000;
  localparam logic [31:0] FRAC_FIELD = 32'h007F_FFFF;
  localparam logic [31:0] INT_MAX    = 32'h7FFF_FFFF;
  localparam int          EXP_BIAS   = 127;
  localparam int          FRAC_BITS  = 23;

  // position of the highest set bit (0 when the word is zero)
  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ----- design/float_add_sub_convert.sv -----
// ----------------------------------------------------------------------------
// float_add_sub_convert
// Single-precision add, subtract, negate and int/float conversion pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries func_i, operand_a_i and
//   operand_b_i. A transaction completes on a rising edge with valid high
//   and stall low. Output channel out_valid_o / out_stall_i carries
//   result_word_o and range_flag_o, one result per input transaction, in
//   order.
//   The three registered stages are operand unpack and alignment, magnitude
//   add and int shift, then normalize and pack into the output register.
//   Throughput is one transaction per cycle while out_stall_i is low; the
//   three stage registers advance independently, so bubbles are squeezed out.
//   When the receiver stalls, the result holds and earlier stages keep
//   filling; in_stall_o rises only once all three stages are occupied.
//   Reset clears all stage valid bits; no result is pending afterwards.
//   Rounding is truncation; NaN and infinity get no special handling.
// ----------------------------------------------------------------------------
module float_add_sub_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_word_o,
  output logic        range_flag_o
);
  import fasc_pkg::*;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // stage 1
  func_e       func1_q;
  logic        sign1_q, esub1_q;
  logic [7:0]  exp1_q;
  logic [23:0] m1_q, m2_q;
  logic [31:0] word1_q;

  func_e       func1_d;
  logic        sign1_d, esub1_d;
  logic [7:0]  exp1_d;
  logic [23:0] m1_d, m2_d;
  logic [31:0] word1_d;

  // stage 2
  func_e       func2_q;
  logic        sign2_q, ovf2_q;
  logic signed [9:0] base2_q;
  logic [31:0] val2_q;

  logic        sign2_d, ovf2_d;
  logic signed [9:0] base2_d;
  logic [31:0] val2_d;

  // stage 3
  logic [31:0] res3_d, res3_q;
  logic        flag3_d, flag3_q;

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---- stage 1: unpack, align ----
  always_comb begin
    logic [31:0] bw;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    func1_d = func_e'(func_i);
    bw = operand_b_i ^ ((func_i == FUNC_SUB) ? SIGN_BIT : 32'd0);
    ea = operand_a_i[30:23];
    eb = bw[30:23];
    ma = {(ea != 8'd0), operand_a_i[22:0]};
    mb = {(eb != 8'd0), bw[22:0]};
    sign1_d = operand_a_i[31];
    esub1_d = operand_a_i[31] ^ bw[31];
    word1_d = 32'd0;
    if (ea >= eb) begin
      exp1_d = ea;
      m1_d   = ma;
      m2_d   = mb >> (ea - eb);
    end else begin
      exp1_d = eb;
      m1_d   = ma >> (eb - ea);
      m2_d   = mb;
    end
    case (func_i)
      FUNC_NEG: word1_d = operand_a_i ^ SIGN_BIT;
      FUNC_I2F: word1_d = operand_a_i[31] ? (~operand_a_i + 32'd1) : operand_a_i;
      FUNC_F2I: begin
        exp1_d = ea;
        m1_d   = ma;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      func1_q <= func1_d;
      sign1_q <= sign1_d;
      esub1_q <= esub1_d;
      exp1_q  <= exp1_d;
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      word1_q <= word1_d;
    end
  end

  // ---- stage 2: magnitude add / int shift ----
  always_comb begin
    logic [24:0] mr;
    logic        carry;
    logic signed [9:0] e;
    sign2_d = sign1_q;
    ovf2_d  = 1'b0;
    base2_d = 10'sd0;
    val2_d  = 32'd0;
    mr      = 25'd0;
    carry   = 1'b0;
    e       = $signed({2'b00, exp1_q}) - 10'sd127;
    case (func1_q)
      FUNC_ADD, FUNC_SUB: begin
        if (esub1_q) begin
          mr = sign1_q ? ({1'b0, m2_q} - {1'b0, m1_q}) : ({1'b0, m1_q} - {1'b0, m2_q});
          carry = mr[24];
          if (carry) mr = ~mr + 25'd1;
          sign2_d = carry;
          val2_d  = {8'd0, mr[23:0]};
          base2_d = $signed({2'b00, exp1_q}) - 10'sd23;
        end else begin
          mr = {1'b0, m1_q} + {1'b0, m2_q};
          carry = mr[24];
          val2_d  = carry ? {7'd0, mr} >> 1 : {7'd0, mr};
          base2_d = $signed({2'b00, exp1_q}) + $signed({9'd0, carry}) - 10'sd23;
        end
      end
      FUNC_NEG: val2_d = word1_q;
      FUNC_I2F: begin
        val2_d  = word1_q;
        base2_d = 10'sd127;
        sign2_d = sign1_q;
      end
      FUNC_F2I: begin
        if (e < 0) val2_d = 32'd0;
        else if (e <= 10'sd23) val2_d = {8'd0, m1_q} >> (5'd23 - e[4:0]);
        else if (e <= 10'sd31) val2_d = {8'd0, m1_q} << (e[4:0] - 5'd23);
        else val2_d = 32'd0;
        if (sign1_q) ovf2_d = (e > 10'sd31) || (e == 10'sd31 && m1_q != 24'h80_0000);
        else         ovf2_d = (e >= 10'sd31);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      func2_q <= func1_q;
      sign2_q <= sign2_d;
      ovf2_q  <= ovf2_d;
      base2_q <= base2_d;
      val2_q  <= val2_d;
    end
  end

  // ---- stage 3: normalize, pack, saturate ----
  always_comb begin
    logic [4:0]  p;
    logic [31:0] norm;
    logic signed [9:0] eo;
    p    = msb_pos(val2_q);
    norm = val2_q << (5'd31 - p);
    eo   = base2_q + $signed({5'd0, p});
    res3_d  = 32'd0;
    flag3_d = 1'b0;
    case (func2_q)
      FUNC_ADD, FUNC_SUB, FUNC_I2F: begin
        if (val2_q == 32'd0) begin
          res3_d = {sign2_q, 31'd0};
        end else if (eo >= 10'sd255) begin
          res3_d  = {sign2_q, 31'd0} | EXP_FIELD;
          flag3_d = 1'b1;
        end else if (eo <= 10'sd0) begin
          res3_d  = {sign2_q, 31'd0};
          flag3_d = 1'b1;
        end else begin
          res3_d = {sign2_q, eo[7:0], norm[30:8]};
        end
      end
      FUNC_NEG: res3_d = val2_q;
      FUNC_F2I: begin
        flag3_d = ovf2_q;
        if (sign2_q) res3_d = ovf2_q ? SIGN_BIT : (~val2_q + 32'd1);
        else         res3_d = ovf2_q ? INT_MAX : val2_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      res3_q  <= res3_d;
      flag3_q <= flag3_d;
    end
  end

  assign out_valid_o   = v3_q;
  assign result_word_o = res3_q;
  assign range_flag_o  = flag3_q;

endmodule

// ----- design/float_add_sub_convert_checker.sv -----
// ----------------------------------------------------------------------------
// float_add_sub_convert_checker
// Port-level checks for the float add/sub/convert unit.
// ----------------------------------------------------------------------------
module float_add_sub_convert_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_word_o,
  input logic        range_flag_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("input transaction withdrawn while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_word_o) && $stable(range_flag_o))
    else $error("stalled result changed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in pipeline");

  a_flag_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_flag_o |->
      result_word_o[30:0] == 31'd0 || result_word_o[30:0] == 31'h7F80_0000 ||
      result_word_o == 32'h7FFF_FFFF)
    else $error("range flag with ordinary result");

endmodule

bind float_add_sub_convert float_add_sub_convert_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .result_word_o(result_word_o),
  .range_flag_o (range_flag_o)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for float_add_sub_convert: directed corner operands,
// then random traffic with random gaps and receiver stalls, two long hold-offs
// to fill the pipeline. Results are compared against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fasc_pkg::*;

  class fpu_scoreboard;
    logic [32:0] pending[$];
    int          errors;

    function automatic logic [32:0] add_words(logic [31:0] a, logic [31:0] b);
      logic        sa, sb, sgn, cy, es;
      int          ea, eb, d, ex, lz;
      logic [31:0] ma, mb, m1, m2, mr;
      sa = a[31];
      sb = b[31];
      ea = int'(a[30:23]);
      eb = int'(b[30:23]);
      ma = {9'd0, a[22:0]};
      mb = {9'd0, b[22:0]};
      if (ea != 0) ma[23] = 1'b1;
      if (eb != 0) mb[23] = 1'b1;
      d = ea - eb;
      if (d > 24) d = 24;
      if (d < -24) d = -24;
      m1 = ma;
      m2 = mb;
      if (d >= 0) begin
        ex = ea;
        m2 = mb >> d;
      end else begin
        ex = eb;
        m1 = ma >> (-d);
      end
      es = sa ^ sb;
      if (es) mr = sa ? m2 - m1 : m1 - m2;
      else mr = m1 + m2;
      cy = mr[24];
      if (es && cy) mr = ~mr + 32'd1;
      if (!es) begin
        mr = mr >> cy;
        ex = ex + int'(cy);
      end
      sgn = es ? cy : sa;
      if (mr == 0) return {1'b0, sgn, 31'd0};
      lz = 0;
      while (lz < 23 && mr[23 - lz] == 1'b0) lz++;
      ex = ex - lz;
      mr = (mr << lz) & FRAC_FIELD;
      if (ex >= 255) return {1'b1, sgn, 31'd0 | EXP_FIELD[30:0]};
      if (ex <= 0) return {1'b1, sgn, 31'd0};
      return {1'b0, sgn, ex[7:0], mr[22:0]};
    endfunction

    function automatic logic [31:0] int_to_word(logic [31:0] v);
      logic [31:0] mag, fr;
      int          p;
      mag = v[31] ? ~v + 32'd1 : v;
      if (mag == 0) return 32'd0;
      p = 31;
      while (mag[p] == 1'b0) p--;
      fr = mag;
      fr[p] = 1'b0;
      if (p >= 23) fr = fr >> (p - 23);
      else fr = fr << (23 - p);
      return {v[31], 8'(p + 127), fr[22:0]};
    endfunction

    function automatic logic [32:0] word_to_int(logic [31:0] a);
      int          e;
      logic [63:0] m, mag;
      e = int'(a[30:23]) - 127;
      m = {41'd0, a[22:0]};
      if (a[30:23] != 0) m[23] = 1'b1;
      if (e < 0) return 33'd0;
      if (e <= 23) mag = m >> (23 - e);
      else if (e <= 40) mag = m << (e - 23);
      else mag = 64'd1 << 40;
      if (!a[31]) begin
        if (mag > 64'h7FFF_FFFF) return {1'b1, INT_MAX};
        return {1'b0, mag[31:0]};
      end
      if (mag > 64'h8000_0000) return {1'b1, SIGN_BIT};
      return {1'b0, ~mag[31:0] + 32'd1};
    endfunction

    function void note_op(logic [2:0] f, logic [31:0] a, logic [31:0] b);
      logic [32:0] r;
      case (f)
        FUNC_ADD: r = add_words(a, b);
        FUNC_SUB: r = add_words(a, b ^ SIGN_BIT);
        FUNC_NEG: r = {1'b0, a ^ SIGN_BIT};
        FUNC_I2F: r = {1'b0, int_to_word(a)};
        FUNC_F2I: r = word_to_int(a);
        default:  r = 33'd0;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] w, logic fl);
      logic [32:0] x;
      if (pending.size() == 0) begin
        $error("unexpected result %h", w);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x[31:0] !== w) begin
        $error("result_word expected %h actual %h", x[31:0], w);
        errors++;
      end
      if (x[32] !== fl) begin
        $error("range_flag expected %b actual %b", x[32], fl);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_word_o;
  logic        range_flag_o;

  fpu_scoreboard sb = new();
  bit            hold_req;
  bit            sending = 1'b1;
  int unsigned   cycles;

  float_add_sub_convert u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'd0;
      1: w[30:23] = 8'hFF - 8'($urandom_range(0, 2));
      2: w[30:23] = 8'(127 + $urandom_range(0, 35));
      3: w = $urandom_range(0, 1) ? {1'b0, 31'($urandom_range(0, 7))} : ~32'd0 - 8;
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_op(logic [2:0] f, logic [31:0] a, logic [31:0] b);
    repeat (gap_len()) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    func_i      <= f;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_op(f, a, b);
  endtask

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(result_word_o, range_flag_o);

  initial begin : recv
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        for (n = 0; n < 40; n++) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (sending && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        n = gap_len() + 1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] corner[8];
    int          i, j;
    corner = '{32'h0, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
               32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000, 32'hFFFF_FFFF};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    send_op(FUNC_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_op(FUNC_SUB, 32'h3F80_0000, 32'h3F80_0000);
    send_op(FUNC_ADD, 32'hBF80_0000, 32'hBF80_0000);
    send_op(FUNC_SUB, 32'h0080_0000, 32'h0080_0001);
    send_op(FUNC_ADD, 32'h4B80_0000, 32'h3F80_0000);
    send_op(FUNC_NEG, 32'h0, 32'h0);
    send_op(FUNC_I2F, 32'h0, 32'h0);
    send_op(FUNC_I2F, 32'h8000_0000, 32'h0);
    send_op(FUNC_I2F, 32'h7FFF_FFFF, 32'h0);
    send_op(FUNC_I2F, 32'hFFFF_FFFF, 32'h0);
    send_op(FUNC_F2I, 32'h3F00_0000, 32'h0);
    send_op(FUNC_F2I, 32'h4F00_0000, 32'h0);
    send_op(FUNC_F2I, 32'hCF00_0000, 32'h0);
    send_op(FUNC_F2I, 32'hCF00_0001, 32'h0);
    send_op(FUNC_F2I, 32'h7F80_0000, 32'h0);
    send_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(3'd6, 32'h1, 32'h1);
    send_op(3'd7, 32'h2, 32'h2);
    for (i = 0; i < 4; i++) begin
      j = $urandom_range(0, 7);
      send_op(FUNC_ADD, corner[i * 2], corner[j]);
    end
    hold_req = 1'b1;
    for (i = 0; i < 1950; i++) begin
      if (i == 900) hold_req = 1'b1;
      send_op(3'($urandom_range(0, 19) == 0 ? $urandom_range(5, 7) : $urandom_range(0, 4)),
              rand_word(), rand_word());
    end
    @(negedge clk_i) in_valid_i <= 1'b0;
    sending = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
